[rtl/sli_pkg.sv]
// Package for the segment/line intersection block: widths and payload types.
// No dependencies.
package sli_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int CROSS_WIDTH     = 32;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] a_start_x;
      logic signed [COORD_WIDTH_DEF-1:0] a_start_y;
      logic signed [COORD_WIDTH_DEF-1:0] a_end_x;
      logic signed [COORD_WIDTH_DEF-1:0] a_end_y;
      logic signed [COORD_WIDTH_DEF-1:0] b_start_x;
      logic signed [COORD_WIDTH_DEF-1:0] b_start_y;
      logic signed [COORD_WIDTH_DEF-1:0] b_end_x;
      logic signed [COORD_WIDTH_DEF-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic                          parallel;
      logic signed [CROSS_WIDTH-1:0] cross_x;
      logic signed [CROSS_WIDTH-1:0] cross_y;
      logic                          saturated;
   } rsp_type;

endpackage

[rtl/segment_line_intersection.sv]
// Top level of the segment/line intersection block.
// Depends on sli_pkg for the payload types and default widths.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | req_data (req_type)
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//
// One transaction per cycle while rsp_ is not stalled. A transaction accepted on req_
// passes through 79 register stages to rsp_: six arithmetic stages, one overflow
// check, 34 quotient-bit stages, two point/square stages, 35 root-bit stages
// and the output register.
// Reset clears only the stage valid bits. A stall on rsp_ freezes the whole
// chain; req_stall is then high, nothing is dropped or repeated.
module segment_line_intersection import sli_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int CW  = COORD_WIDTH_DEF;
   localparam int DW  = CW + 1;            // differences
   localparam int PW  = 2 * DW + 1;        // c terms and det
   localparam int NW  = PW + DW + 2;       // Cramer numerators
   localparam int QB  = 34;                // quotient bits kept (sat detect)
   localparam int DQ  = CROSS_WIDTH + 2;   // point - endpoint difference
   localparam int SQW = 2 * DQ + 2;        // squared distance
   localparam int RW  = SQW / 2;           // root width

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage 1: differences
   logic                 v1_ff;
   logic signed [DW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [CW-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff, bx1_ff, by1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
      if (adv) begin
         a1_ff <= DW'($signed(req_data.a_end_y[CW-1:0]))
                  - DW'($signed(req_data.a_start_y[CW-1:0]));
         b1_ff <= DW'($signed(req_data.a_start_x[CW-1:0]))
                  - DW'($signed(req_data.a_end_x[CW-1:0]));
         a2_ff <= DW'($signed(req_data.b_end_y[CW-1:0]))
                  - DW'($signed(req_data.b_start_y[CW-1:0]));
         b2_ff <= DW'($signed(req_data.b_start_x[CW-1:0]))
                  - DW'($signed(req_data.b_end_x[CW-1:0]));
         ax1_ff <= req_data.a_start_x[CW-1:0];
         ay1_ff <= req_data.a_start_y[CW-1:0];
         ax2_ff <= req_data.a_end_x[CW-1:0];
         ay2_ff <= req_data.a_end_y[CW-1:0];
         bx1_ff <= req_data.b_start_x[CW-1:0];
         by1_ff <= req_data.b_start_y[CW-1:0];
      end
   end

   // ---------------- stage 2: products for c and det
   logic                 v2_ff;
   logic signed [PW-1:0] p_a1x_ff, p_b1y_ff, p_a2x_ff, p_b2y_ff, p_a1b2_ff, p_a2b1_ff;
   logic signed [DW-1:0] a1_2ff, b1_2ff, a2_2ff, b2_2ff;
   logic signed [CW-1:0] ax1_2ff, ay1_2ff, ax2_2ff, ay2_2ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         p_a1x_ff  <= PW'(a1_ff) * PW'(ax1_ff);
         p_b1y_ff  <= PW'(b1_ff) * PW'(ay1_ff);
         p_a2x_ff  <= PW'(a2_ff) * PW'(bx1_ff);
         p_b2y_ff  <= PW'(b2_ff) * PW'(by1_ff);
         p_a1b2_ff <= PW'(a1_ff) * PW'(b2_ff);
         p_a2b1_ff <= PW'(a2_ff) * PW'(b1_ff);
         a1_2ff <= a1_ff; b1_2ff <= b1_ff; a2_2ff <= a2_ff; b2_2ff <= b2_ff;
         ax1_2ff <= ax1_ff; ay1_2ff <= ay1_ff; ax2_2ff <= ax2_ff; ay2_2ff <= ay2_ff;
      end
   end

   // ---------------- stage 3: c1, c2, det sums
   logic                 v3_ff;
   logic signed [PW-1:0] c1_ff, c2_ff, det_ff;
   logic signed [DW-1:0] a1_3ff, b1_3ff, a2_3ff, b2_3ff;
   logic signed [CW-1:0] ax1_3ff, ay1_3ff, ax2_3ff, ay2_3ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         c1_ff  <= p_a1x_ff + p_b1y_ff;
         c2_ff  <= p_a2x_ff + p_b2y_ff;
         det_ff <= p_a1b2_ff - p_a2b1_ff;
         a1_3ff <= a1_2ff; b1_3ff <= b1_2ff; a2_3ff <= a2_2ff; b2_3ff <= b2_2ff;
         ax1_3ff <= ax1_2ff; ay1_3ff <= ay1_2ff; ax2_3ff <= ax2_2ff; ay2_3ff <= ay2_2ff;
      end
   end

   // ---------------- stage 4a: numerator partial products; c is split into
   // a signed high slice and an unsigned low slice
   localparam int LB  = 26;             // low slice of c
   localparam int HW  = PW - LB;        // high slice of c
   localparam int LPW = DW + LB + 1;    // low partial product
   localparam int HPW = DW + HW;        // high partial product
   logic                  v4a_ff;
   logic signed [LPW-1:0] l_b2c1_ff, l_b1c2_ff, l_a1c2_ff, l_a2c1_ff;
   logic signed [HPW-1:0] h_b2c1_ff, h_b1c2_ff, h_a1c2_ff, h_a2c1_ff;
   logic signed [PW-1:0]  det_4aff;
   logic signed [CW-1:0]  ax1_4aff, ay1_4aff, ax2_4aff, ay2_4aff;
   logic signed [LB:0]    c1_lo, c2_lo;
   logic signed [HW-1:0]  c1_hi, c2_hi;
   always_comb begin
      c1_lo = $signed({1'b0, c1_ff[LB-1:0]});
      c2_lo = $signed({1'b0, c2_ff[LB-1:0]});
      c1_hi = c1_ff[PW-1:LB];
      c2_hi = c2_ff[PW-1:LB];
   end
   always_ff @(posedge clock) begin
      if (reset) v4a_ff <= 1'b0;
      else if (adv) v4a_ff <= v3_ff;
      if (adv) begin
         l_b2c1_ff <= LPW'(b2_3ff) * LPW'(c1_lo);
         l_b1c2_ff <= LPW'(b1_3ff) * LPW'(c2_lo);
         l_a1c2_ff <= LPW'(a1_3ff) * LPW'(c2_lo);
         l_a2c1_ff <= LPW'(a2_3ff) * LPW'(c1_lo);
         h_b2c1_ff <= HPW'(b2_3ff) * HPW'(c1_hi);
         h_b1c2_ff <= HPW'(b1_3ff) * HPW'(c2_hi);
         h_a1c2_ff <= HPW'(a1_3ff) * HPW'(c2_hi);
         h_a2c1_ff <= HPW'(a2_3ff) * HPW'(c1_hi);
         det_4aff <= det_ff;
         ax1_4aff <= ax1_3ff; ay1_4aff <= ay1_3ff; ax2_4aff <= ax2_3ff; ay2_4aff <= ay2_3ff;
      end
   end

   // ---------------- stage 4b: recombine the partial products
   logic                 v4_ff;
   logic signed [NW-1:0] n_b2c1_ff, n_b1c2_ff, n_a1c2_ff, n_a2c1_ff;
   logic signed [PW-1:0] det_4ff;
   logic signed [CW-1:0] ax1_4ff, ay1_4ff, ax2_4ff, ay2_4ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v4a_ff;
      if (adv) begin
         n_b2c1_ff <= (NW'(h_b2c1_ff) << LB) + NW'(l_b2c1_ff);
         n_b1c2_ff <= (NW'(h_b1c2_ff) << LB) + NW'(l_b1c2_ff);
         n_a1c2_ff <= (NW'(h_a1c2_ff) << LB) + NW'(l_a1c2_ff);
         n_a2c1_ff <= (NW'(h_a2c1_ff) << LB) + NW'(l_a2c1_ff);
         det_4ff <= det_4aff;
         ax1_4ff <= ax1_4aff; ay1_4ff <= ay1_4aff; ax2_4ff <= ax2_4aff; ay2_4ff <= ay2_4aff;
      end
   end

   // ---------------- stage 5: magnitudes and signs; A's length squared
   logic                 v5_ff, par5_ff, negx5_ff, negy5_ff;
   logic [NW-1:0]        nx5_ff, ny5_ff;
   logic [PW-1:0]        den5_ff;
   logic [SQW-1:0]       len5_ff;
   logic signed [CW-1:0] ax1_5ff, ay1_5ff, ax2_5ff, ay2_5ff;
   logic signed [NW-1:0] nx_s, ny_s;
   logic signed [DW-1:0] ldx, ldy;
   always_comb begin
      nx_s = n_b2c1_ff - n_b1c2_ff;
      ny_s = n_a1c2_ff - n_a2c1_ff;
      ldx  = DW'(ax2_4ff) - DW'(ax1_4ff);
      ldy  = DW'(ay2_4ff) - DW'(ay1_4ff);
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         par5_ff  <= (det_4ff == '0);
         negx5_ff <= nx_s[NW-1] ^ det_4ff[PW-1];
         negy5_ff <= ny_s[NW-1] ^ det_4ff[PW-1];
         nx5_ff   <= nx_s[NW-1] ? NW'(-nx_s) : NW'(nx_s);
         ny5_ff   <= ny_s[NW-1] ? NW'(-ny_s) : NW'(ny_s);
         den5_ff  <= det_4ff[PW-1] ? PW'(-det_4ff) : PW'(det_4ff);
         len5_ff  <= SQW'(SQW'(ldx) * SQW'(ldx)) + SQW'(SQW'(ldy) * SQW'(ldy));
         ax1_5ff <= ax1_4ff; ay1_5ff <= ay1_4ff; ax2_5ff <= ax2_4ff; ay2_5ff <= ay2_4ff;
      end
   end

   // ---------------- divider chain: one quotient bit per stage, top bits
   // of the quotient collapse into an overflow flag first.
   typedef struct packed {
      logic          vld, par, negx, negy, ovx, ovy;
      logic [NW-1:0] rx, ry;        // partial remainder with dividend tail
      logic [QB-1:0] qx, qy;
      logic [PW-1:0] den;
      logic [SQW-1:0] len;
      logic signed [CW-1:0] ax1, ay1, ax2, ay2;
   } dstg_type;

   // Quotient bits at QB and above only matter as overflow: one compare of
   // the numerator against den << QB in a pre-stage.
   dstg_type d0_ff;
   logic [NW+QB-1:0] lim;
   always_comb lim = (NW+QB)'(den5_ff) << QB;
   always_ff @(posedge clock) begin
      if (reset) d0_ff.vld <= 1'b0;
      else if (adv) d0_ff.vld <= v5_ff;
      if (adv) begin
         d0_ff.par  <= par5_ff;
         d0_ff.negx <= negx5_ff;
         d0_ff.negy <= negy5_ff;
         d0_ff.ovx  <= (NW+QB)'(nx5_ff) >= lim;
         d0_ff.ovy  <= (NW+QB)'(ny5_ff) >= lim;
         d0_ff.rx   <= nx5_ff;
         d0_ff.ry   <= ny5_ff;
         d0_ff.qx   <= '0;
         d0_ff.qy   <= '0;
         d0_ff.den  <= den5_ff;
         d0_ff.len  <= len5_ff;
         d0_ff.ax1 <= ax1_5ff; d0_ff.ay1 <= ay1_5ff;
         d0_ff.ax2 <= ax2_5ff; d0_ff.ay2 <= ay2_5ff;
      end
   end

   // Each stage k decides quotient bit QB-1-k: compare remainder with den<<bit.
   dstg_type dq_ff [QB];
   for (genvar k = 0; k < QB; k++) begin : g_div
      dstg_type src, nxt;
      localparam int SH = QB - 1 - k;
      logic [NW+QB-1:0] dsh;
      always_comb begin
         src = (k == 0) ? d0_ff : dq_ff[(k == 0) ? 0 : k-1];
         nxt = src;
         dsh = (NW+QB)'(src.den) << SH;
         if ((NW+QB)'(src.rx) >= dsh) begin
            nxt.rx = NW'((NW+QB)'(src.rx) - dsh);
            nxt.qx[SH] = 1'b1;
         end
         if ((NW+QB)'(src.ry) >= dsh) begin
            nxt.ry = NW'((NW+QB)'(src.ry) - dsh);
            nxt.qy[SH] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dq_ff[k].vld <= 1'b0;
         else if (adv) dq_ff[k].vld <= src.vld;
         if (adv) begin
            dq_ff[k].par  <= nxt.par;  dq_ff[k].negx <= nxt.negx;
            dq_ff[k].negy <= nxt.negy; dq_ff[k].ovx  <= nxt.ovx;
            dq_ff[k].ovy  <= nxt.ovy;  dq_ff[k].rx   <= nxt.rx;
            dq_ff[k].ry   <= nxt.ry;   dq_ff[k].qx   <= nxt.qx;
            dq_ff[k].qy   <= nxt.qy;   dq_ff[k].den  <= nxt.den;
            dq_ff[k].len  <= nxt.len;
            dq_ff[k].ax1 <= nxt.ax1; dq_ff[k].ay1 <= nxt.ay1;
            dq_ff[k].ax2 <= nxt.ax2; dq_ff[k].ay2 <= nxt.ay2;
         end
      end
   end

   // ---------------- saturate, form point-to-endpoint squares
   logic                   v6_ff, par6_ff, sat6_ff;
   logic signed [CROSS_WIDTH-1:0] px6_ff, py6_ff;
   logic [SQW-1:0]         s1_6ff, s2_6ff, s3_6ff;
   logic signed [CROSS_WIDTH-1:0] px_c, py_c;
   logic                   satx, saty;
   logic signed [DQ-1:0]   e1x, e1y, e2x, e2y;
   localparam logic [QB-1:0] MAXP = QB'({1'b0, {(CROSS_WIDTH-1){1'b1}}});
   localparam logic [QB-1:0] MAXN = QB'({1'b1, {(CROSS_WIDTH-1){1'b0}}});
   dstg_type dl;
   always_comb begin
      dl = dq_ff[QB-1];
      satx = dl.ovx || (dl.negx ? (dl.qx > MAXN) : (dl.qx > MAXP));
      saty = dl.ovy || (dl.negy ? (dl.qy > MAXN) : (dl.qy > MAXP));
      if (satx) px_c = dl.negx ? {1'b1, {(CROSS_WIDTH-1){1'b0}}}
                               : {1'b0, {(CROSS_WIDTH-1){1'b1}}};
      else      px_c = dl.negx ? CROSS_WIDTH'(-dl.qx) : CROSS_WIDTH'(dl.qx);
      if (saty) py_c = dl.negy ? {1'b1, {(CROSS_WIDTH-1){1'b0}}}
                               : {1'b0, {(CROSS_WIDTH-1){1'b1}}};
      else      py_c = dl.negy ? CROSS_WIDTH'(-dl.qy) : CROSS_WIDTH'(dl.qy);
      e1x = DQ'(dl.ax1) - DQ'(px_c);
      e1y = DQ'(dl.ay1) - DQ'(py_c);
      e2x = DQ'(dl.ax2) - DQ'(px_c);
      e2y = DQ'(dl.ay2) - DQ'(py_c);
   end
   logic signed [DQ-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic v6a_ff, par6a_ff, sat6a_ff;
   logic signed [CROSS_WIDTH-1:0] px6a_ff, py6a_ff;
   logic [SQW-1:0] len6a_ff;
   always_ff @(posedge clock) begin
      if (reset) v6a_ff <= 1'b0;
      else if (adv) v6a_ff <= dl.vld;
      if (adv) begin
         par6a_ff <= dl.par; sat6a_ff <= satx || saty;
         px6a_ff <= px_c; py6a_ff <= py_c;
         e1x_ff <= e1x; e1y_ff <= e1y; e2x_ff <= e2x; e2y_ff <= e2y;
         len6a_ff <= dl.len;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v6a_ff;
      if (adv) begin
         par6_ff <= par6a_ff; sat6_ff <= sat6a_ff;
         px6_ff <= px6a_ff; py6_ff <= py6a_ff;
         s1_6ff <= SQW'(SQW'(e1x_ff) * SQW'(e1x_ff)) + SQW'(SQW'(e1y_ff) * SQW'(e1y_ff));
         s2_6ff <= SQW'(SQW'(e2x_ff) * SQW'(e2x_ff)) + SQW'(SQW'(e2y_ff) * SQW'(e2y_ff));
         s3_6ff <= len6a_ff;
      end
   end

   // ---------------- square-root chain: one root bit per stage, three lanes
   typedef struct packed {
      logic vld, par, sat;
      logic signed [CROSS_WIDTH-1:0] px, py;
      logic [SQW-1:0] r1, r2, r3;    // remainders
      logic [RW-1:0]  q1, q2, q3;    // roots
   } rstg_type;
   rstg_type rs_ff [RW];

   function automatic logic [SQW+RW-1:0] sq_step(input logic [SQW-1:0] r,
                                                  input logic [RW-1:0] q,
                                                  input int b);
      logic [SQW+1:0] t;
      logic [RW-1:0]  qn;
      t  = ((SQW+2)'(q) << (b + 1)) + ((SQW+2)'(1) << (2 * b));
      qn = q;
      if ((SQW+2)'(r) >= t) begin
         qn[b] = 1'b1;
         return {SQW'((SQW+2)'(r) - t), qn};
      end
      return {r, qn};
   endfunction

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      rstg_type src, nxt;
      localparam int B = RW - 1 - k;
      always_comb begin
         if (k == 0) begin
            src.vld = v6_ff; src.par = par6_ff; src.sat = sat6_ff;
            src.px = px6_ff; src.py = py6_ff;
            src.r1 = s1_6ff; src.r2 = s2_6ff; src.r3 = s3_6ff;
            src.q1 = '0; src.q2 = '0; src.q3 = '0;
         end else begin
            src = rs_ff[(k == 0) ? 0 : k-1];
         end
         nxt = src;
         {nxt.r1, nxt.q1} = sq_step(src.r1, src.q1, B);
         {nxt.r2, nxt.q2} = sq_step(src.r2, src.q2, B);
         {nxt.r3, nxt.q3} = sq_step(src.r3, src.q3, B);
      end
      always_ff @(posedge clock) begin
         if (reset) rs_ff[k].vld <= 1'b0;
         else if (adv) rs_ff[k].vld <= src.vld;
         if (adv) begin
            rs_ff[k].par <= nxt.par; rs_ff[k].sat <= nxt.sat;
            rs_ff[k].px <= nxt.px;   rs_ff[k].py <= nxt.py;
            rs_ff[k].r1 <= nxt.r1;   rs_ff[k].r2 <= nxt.r2; rs_ff[k].r3 <= nxt.r3;
            rs_ff[k].q1 <= nxt.q1;   rs_ff[k].q2 <= nxt.q2; rs_ff[k].q3 <= nxt.q3;
         end
      end
   end

   // ---------------- output register: distance test, parallel zeroing
   rstg_type rl;
   logic [RW:0] dsum;
   logic        hit_c;
   always_comb begin
      rl = rs_ff[RW-1];
      dsum = (RW+1)'(rl.q1) + (RW+1)'(rl.q2);
      hit_c = (dsum >> FRAC_BITS) == (RW+1)'(rl.q3 >> FRAC_BITS);
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= rl.vld;
      if (adv) begin
         rsp_data.parallel  <= rl.par;
         rsp_data.hit       <= rl.par ? 1'b0 : hit_c;
         rsp_data.cross_x   <= rl.par ? '0 : rl.px;
         rsp_data.cross_y   <= rl.par ? '0 : rl.py;
         rsp_data.saturated <= rl.par ? 1'b0 : rl.sat;
      end
   end

endmodule

[rtl/sli_checker.sv]
// Port-level checker for segment_line_intersection, bound to the top level.
// Depends on sli_pkg for the payload types.
module sli_checker import sli_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed under stall");
   // input stall follows output stall
   a_bp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without output backpressure");
   // parallel results carry zero point
   a_par: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parallel |->
         rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && !rsp_data.hit
         && !rsp_data.saturated)
      else $error("parallel result with nonzero fields");
   // no result right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind segment_line_intersection sli_checker u_sli_checker (.*);

[tb/tb_segment_line_intersection.sv]
// Testbench for segment_line_intersection: random and directed segment pairs,
// an in-bench predictor of the crossing point and the on-segment test.
// Depends on sli_pkg and the segment_line_intersection RTL.

class crossing_scoreboard;
   sli_pkg::rsp_type pending_q[$];
   int               errors;

   function new();
      errors = 0;
   endfunction

   // floor of the square root of an unsigned value below 2^80
   function logic [127:0] floor_root(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] trial;
      root = '0;
      for (int i = 40; i >= 0; i--) begin
         trial = root | (128'd1 << i);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function logic [127:0] seg_len(logic signed [127:0] x0, logic signed [127:0] y0,
                                  logic signed [127:0] x1, logic signed [127:0] y1);
      logic signed [127:0] dx;
      logic signed [127:0] dy;
      dx = x1 - x0;
      dy = y1 - y0;
      return floor_root(dx * dx + dy * dy);
   endfunction

   // quotient truncated toward zero, clipped to 32 bits
   function logic signed [127:0] clip_quot(logic signed [127:0] num,
                                           logic signed [127:0] den, inout bit clipped);
      logic signed [127:0] q;
      q = num / den;
      if (q > 128'sd2147483647) begin
         clipped = 1'b1;
         return 128'sd2147483647;
      end
      if (q < -128'sd2147483648) begin
         clipped = 1'b1;
         return -128'sd2147483648;
      end
      return q;
   endfunction

   // predict the crossing for one accepted pair
   function void note_pair(sli_pkg::req_type p);
      logic signed [127:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      logic signed [127:0] a1, b1, a2, b2, c1, c2, det, px, py;
      logic [127:0]        d1, d2, d3;
      sli_pkg::rsp_type    r;
      bit                  clipped;
      ax1 = p.a_start_x; ay1 = p.a_start_y; ax2 = p.a_end_x; ay2 = p.a_end_y;
      bx1 = p.b_start_x; by1 = p.b_start_y; bx2 = p.b_end_x; by2 = p.b_end_y;
      a1 = ay2 - ay1; b1 = ax1 - ax2;
      a2 = by2 - by1; b2 = bx1 - bx2;
      c1 = a1 * ax1 + b1 * ay1;
      c2 = a2 * bx1 + b2 * by1;
      det = a1 * b2 - a2 * b1;
      r = '0;
      if (det == 0) begin
         r.parallel = 1'b1;
      end else begin
         clipped = 1'b0;
         px = clip_quot(b2 * c1 - b1 * c2, det, clipped);
         py = clip_quot(a1 * c2 - a2 * c1, det, clipped);
         d1 = seg_len(px, py, ax1, ay1);
         d2 = seg_len(px, py, ax2, ay2);
         d3 = seg_len(ax1, ay1, ax2, ay2);
         r.hit       = ((d1 + d2) >> sli_pkg::FRAC_BITS_DEF) == (d3 >> sli_pkg::FRAC_BITS_DEF);
         r.cross_x   = px[31:0];
         r.cross_y   = py[31:0];
         r.saturated = clipped;
      end
      pending_q.insert(pending_q.size(), r);
   endfunction

   function void check_result(sli_pkg::rsp_type got);
      sli_pkg::rsp_type want;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result %p", $time, got);
         errors++;
         return;
      end
      want = pending_q.pop_front();
      if (got.hit !== want.hit) begin
         $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
         errors++;
      end
      if (got.parallel !== want.parallel) begin
         $display("%0t: parallel expected %0b actual %0b", $time, want.parallel, got.parallel);
         errors++;
      end
      if (got.cross_x !== want.cross_x) begin
         $display("%0t: cross_x expected %0d actual %0d", $time, want.cross_x, got.cross_x);
         errors++;
      end
      if (got.cross_y !== want.cross_y) begin
         $display("%0t: cross_y expected %0d actual %0d", $time, want.cross_y, got.cross_y);
         errors++;
      end
      if (got.saturated !== want.saturated) begin
         $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                  got.saturated);
         errors++;
      end
   endfunction
endclass

module tb_segment_line_intersection;
   import sli_pkg::*;

   localparam int NUM_RANDOM  = 480;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_WAIT  = 300;
   localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
   localparam logic signed [23:0] CMIN = 24'sh800000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   crossing_scoreboard sb;
   int  sent_count;
   int  idle_cycles;
   int  stall_left;
   bit  hold_done;
   bit  quiet;

   segment_line_intersection dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // short gaps mostly, an occasional long one
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // monitor: record transactions on both channels, watchdog on progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && !req_stall) sb.note_pair(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off while the sender keeps going
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && sent_count >= 200) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   task automatic send_pair(req_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic req_type make_pair(int ax1, int ay1, int ax2, int ay2,
                                         int bx1, int by1, int bx2, int by2);
      req_type p;
      p.a_start_x = 24'(ax1); p.a_start_y = 24'(ay1);
      p.a_end_x   = 24'(ax2); p.a_end_y   = 24'(ay2);
      p.b_start_x = 24'(bx1); p.b_start_y = 24'(by1);
      p.b_end_x   = 24'(bx2); p.b_end_y   = 24'(by2);
      return p;
   endfunction

   function automatic int small_coord(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // random pair: full range, small, through a point of A, exactly or nearly parallel
   function automatic req_type random_pair();
      req_type p;
      int kind, ax1, ay1, ax2, ay2, px, py, dx, dy, t;
      kind = $urandom_range(0, 9);
      ax1 = small_coord(1 << 20); ay1 = small_coord(1 << 20);
      ax2 = small_coord(1 << 20); ay2 = small_coord(1 << 20);
      case (kind)
         0, 1: begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end
         2, 3: begin
            p = make_pair(small_coord(4000), small_coord(4000), small_coord(4000),
                          small_coord(4000), small_coord(4000), small_coord(4000),
                          small_coord(4000), small_coord(4000));
         end
         4, 5, 6: begin
            // B passes through a point at t/16 along A, t beyond 0..16 falls off
            t  = $urandom_range(0, 20) - 2;
            px = ax1 + ((ax2 - ax1) / 16) * t;
            py = ay1 + ((ay2 - ay1) / 16) * t;
            dx = small_coord(1 << 18);
            dy = small_coord(1 << 18);
            p = make_pair(ax1, ay1, ax2, ay2, px - dx, py - dy, px + dx, py + dy);
         end
         7: begin
            // exactly parallel, shifted copy of A
            dx = small_coord(5000); dy = small_coord(5000);
            p = make_pair(ax1, ay1, ax2, ay2, ax1 + dx, ay1 + dy, ax2 + dx, ay2 + dy);
         end
         default: begin
            // nearly parallel: crossing far away, often clipped
            dx = small_coord(1 << 16); dy = small_coord(1 << 16);
            p = make_pair(ax1, ay1, ax2, ay2, ax1 + dx, ay1 + dy,
                          ax2 + dx + small_coord(2), ay2 + dy + small_coord(2));
         end
      endcase
      return p;
   endfunction

   initial begin
      sb = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      sent_count  = 0;
      idle_cycles = 0;
      stall_left  = 0;
      hold_done   = 1'b0;
      quiet       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, parallel, degenerate A, clipping, on and off segment
      send_pair('0);
      send_pair({8{CMAX}});
      send_pair({8{CMIN}});
      send_pair(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
      send_pair(make_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
      send_pair(make_pair(0, 0, 2560, 0, 0, 256, 2560, 256));
      send_pair(make_pair(100, 100, 100, 100, 0, 0, 256, 512));
      send_pair(make_pair(0, 0, 256, 0, 0, 256, 256, 0));
      send_pair(make_pair(0, 0, 256, 0, 1024, -256, 1024, 256));
      send_pair(make_pair(0, 0, 256, 0, 256, -256, 256, 256));
      send_pair(make_pair(CMIN, 0, CMAX, 1, CMIN, 1, CMAX, 2));
      send_pair(make_pair(CMIN, 1, CMAX, 0, CMIN, 0, CMAX, 0));
      send_pair(make_pair(CMIN, CMIN, CMAX, CMAX - 1, CMIN, CMIN + 1, CMAX, CMAX));
      send_pair(make_pair(0, CMIN, 1, CMAX, 2, CMIN, 2, CMAX));
      send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
      send_pair({4{48'hAAAAAA555555}});
      send_pair({4{48'h555555AAAAAA}});
      send_pair(make_pair(-512, -512, 512, 512, -512, 512, 512, -512));

      // random part, with a burst run without gaps every so often
      for (int i = 0; i < NUM_RANDOM; i++) begin
         quiet = ((i / 60) % 3 == 1);
         send_pair(random_pair());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/sli_pkg.sv
rtl/segment_line_intersection.sv
rtl/sli_checker.sv
tb/tb_segment_line_intersection.sv
